// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL that carries checks.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under a synchronous active-high reset.
`define OBBA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under a synchronous active-high reset.
`define OBBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/obba_pkg.sv =====
// Shared types and constants for the order table best bid/ask block.
// No dependencies; imported by the controller, datapath and top level.
package obba_pkg;

  localparam int ID_W     = 32;
  localparam int PRICE_W  = 27;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;
  localparam int TDATA_W  = 64;

  // Lowest sell price reported when no sell rests (1000000.00 in hundredths)
  localparam logic [PRICE_W-1:0] ASK_SENTINEL = PRICE_W'(100000000);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_MISSING = 2'd2
  } obba_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_SEARCH,
    ST_COMP_RD,
    ST_COMP_WR,
    ST_DEL_DONE,
    ST_RESCAN_INIT,
    ST_RESCAN,
    ST_FINISH
  } obba_state_t;

  // One resting order as stored in the table
  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               side;
    logic [ID_W-1:0]    id;
  } obba_entry_t;

  localparam int ENTRY_W = $bits(obba_entry_t);

  // Controller to datapath commands
  typedef struct packed {
    logic         latch_in;
    logic         ptr_clear;
    logic         scan_rd;
    logic         hit_load;
    logic         comp_rd;
    logic         comp_wr;
    logic         cnt_dec;
    logic         wr_add;
    logic         acc_init;
    logic         acc_upd;
    logic         lvl_load;
    logic         status_load;
    obba_status_t status_code;
    logic         out_load;
  } obba_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic one_left;
    logic scan_end;
    logic hit;
    logic comp_more;
    logic out_free;
  } obba_stat_t;

endpackage

// ===== hw/rtl/order_table_best_bid_ask.sv =====
// Order table with best bid/ask tracking; one transaction at a time, one result each.
// An add appends and rescans the table; a full add does neither. A delete searches, shifts
// the later entries down over the match and rescans unless it drains the table; a missed
// delete only searches. The next transaction is taken in the cycle after the result loads;
// a previous result still waiting on m_tready stalls that load. Synchronous reset empties
// the table (fill count only, RAM not cleared) and clears both levels to zero.
module order_table_best_bid_ask #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata: order_id[31:0], side[32], price[59:33], zero pad [63:60]
  input  logic [obba_pkg::TDATA_W-1:0]      s_tdata,
  // s_tuser: op (0 add, 1 delete)
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata: best_bid[26:0], best_ask[53:27], order_count[60:54], zero pad [63:61]
  output logic [obba_pkg::TDATA_W-1:0]      m_tdata,
  // m_tuser: status (0 done, 1 full, 2 not found)
  output logic [obba_pkg::STATUS_W-1:0]     m_tuser
);
  import obba_pkg::*;

  obba_cmd_t  cmd;
  obba_stat_t stat;

  obba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  obba_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`include "assert_macros.svh"

  `OBBA_ASSERT_IMPLY(a_no_add_when_full, clk, rst, cmd.wr_add, !stat.full, "append into full table")
  `OBBA_ASSERT_IMPLY(a_result_not_lost, clk, rst, cmd.out_load, stat.out_free, "result overwritten")
  `OBBA_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "accept while busy")

endmodule

// ===== hw/rtl/obba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module obba_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/obba_dp.sv =====
// Datapath: order table RAM, fill count, scan pointers, level accumulators
// and the result register. Depends on obba_pkg and obba_ram.
module obba_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  obba_pkg::obba_cmd_t               cmd,
  output obba_pkg::obba_stat_t              stat,
  input  logic [obba_pkg::TDATA_W-1:0]      s_tdata,
  input  logic                              m_tready,
  output logic                              m_tvalid,
  output logic [obba_pkg::TDATA_W-1:0]      m_tdata,
  output logic [obba_pkg::STATUS_W-1:0]     m_tuser
);
  import obba_pkg::*;

  localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW      = $clog2(TABLE_DEPTH + 1);
  localparam int OUT_PAD = TDATA_W - 2 * PRICE_W - COUNT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  obba_entry_t          item;
  logic [CW-1:0]        count;
  logic [CW-1:0]        ptr;
  logic [CW-1:0]        rd_idx;
  logic                 rd_valid;
  logic [CW-1:0]        j;
  logic [CW-1:0]        j_inc;
  logic [PRICE_W-1:0]   bid_acc;
  logic [PRICE_W-1:0]   ask_acc;
  logic [PRICE_W-1:0]   bid_level;
  logic [PRICE_W-1:0]   ask_level;
  obba_status_t         status;
  logic                 ptr_live;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [ENTRY_W-1:0]   wr_data;
  logic [AW-1:0]        rd_addr;
  logic [ENTRY_W-1:0]   rd_raw;
  obba_entry_t          rd_ent;
  logic [CW+COUNT_W-1:0] cnt_ext;

  assign j_inc    = j + 1'b1;
  assign ptr_live = (ptr < count);
  assign rd_ent   = obba_entry_t'(rd_raw);

  // Table write port: append on add, shift down during compaction
  assign wr_en   = cmd.wr_add | cmd.comp_wr;
  assign wr_addr = cmd.wr_add ? count[AW-1:0] : j[AW-1:0];
  assign wr_data = cmd.wr_add ? ENTRY_W'(item) : rd_raw;
  assign rd_addr = cmd.comp_rd ? j_inc[AW-1:0] : ptr[AW-1:0];

  obba_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  // Capture the incoming order
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      item.id    <= s_tdata[ID_W-1:0];
      item.side  <= s_tdata[ID_W];
      item.price <= s_tdata[ID_W+PRICE_W:ID_W+1];
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.wr_add) begin
      count <= count + 1'b1;
    end else if (cmd.cnt_dec) begin
      count <= count - 1'b1;
    end
  end

  // Scan pointer and read-valid tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_rd & ptr_live;
      if (cmd.ptr_clear) begin
        ptr <= '0;
      end else if (cmd.scan_rd && ptr_live) begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= ptr;
  end

  // Compaction index: start at the match, advance per shifted entry
  always_ff @(posedge clk) begin
    if (cmd.hit_load) begin
      j <= rd_idx;
    end else if (cmd.comp_wr) begin
      j <= j_inc;
    end
  end

  // Best-price accumulators over one rescan
  always_ff @(posedge clk) begin
    if (cmd.acc_init) begin
      bid_acc <= '0;
      ask_acc <= ASK_SENTINEL;
    end else if (cmd.acc_upd && rd_valid) begin
      if (rd_ent.side) begin
        if (rd_ent.price > bid_acc) begin
          bid_acc <= rd_ent.price;
        end
      end else begin
        if (rd_ent.price < ask_acc) begin
          ask_acc <= rd_ent.price;
        end
      end
    end
  end

  // Committed levels
  always_ff @(posedge clk) begin
    if (rst) begin
      bid_level <= '0;
      ask_level <= '0;
    end else if (cmd.lvl_load) begin
      bid_level <= bid_acc;
      ask_level <= ask_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.status_load) begin
      status <= cmd.status_code;
    end
  end

  // Result register
  assign cnt_ext = {{COUNT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {{OUT_PAD{1'b0}}, cnt_ext[COUNT_W-1:0], ask_level, bid_level};
      m_tuser <= status;
    end
  end

  // Status toward the controller
  assign stat.full      = (count == DEPTH_C);
  assign stat.one_left  = (count == CW'(1));
  assign stat.scan_end  = !ptr_live && !rd_valid;
  assign stat.hit       = rd_valid && (rd_ent.id == item.id);
  assign stat.comp_more = (j_inc < count);
  assign stat.out_free  = !m_tvalid || m_tready;

endmodule

// ===== hw/rtl/obba_ctrl.sv =====
// Controller state machine: sequences add, search, compaction and rescan.
// Depends on obba_pkg.
module obba_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tuser,
  output logic                 s_tready,
  output obba_pkg::obba_cmd_t  cmd,
  input  obba_pkg::obba_stat_t stat
);
  import obba_pkg::*;

  obba_state_t state;
  obba_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.status_code = STATUS_DONE;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.latch_in  = 1'b1;
          cmd.ptr_clear = 1'b1;
          state_next    = s_tuser ? ST_SEARCH : ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.status_load = 1'b1;
        if (stat.full) begin
          cmd.status_code = STATUS_FULL;
          state_next      = ST_FINISH;
        end else begin
          cmd.wr_add = 1'b1;
          state_next = ST_RESCAN_INIT;
        end
      end
      ST_SEARCH: begin
        if (stat.hit) begin
          cmd.hit_load = 1'b1;
          state_next   = ST_COMP_RD;
        end else if (stat.scan_end) begin
          cmd.status_load = 1'b1;
          cmd.status_code = STATUS_MISSING;
          state_next      = ST_FINISH;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      ST_COMP_RD: begin
        if (stat.comp_more) begin
          cmd.comp_rd = 1'b1;
          state_next  = ST_COMP_WR;
        end else begin
          state_next = ST_DEL_DONE;
        end
      end
      ST_COMP_WR: begin
        cmd.comp_wr = 1'b1;
        state_next  = ST_COMP_RD;
      end
      ST_DEL_DONE: begin
        cmd.cnt_dec     = 1'b1;
        cmd.status_load = 1'b1;
        // Keep the old levels when the table drains
        state_next = stat.one_left ? ST_FINISH : ST_RESCAN_INIT;
      end
      ST_RESCAN_INIT: begin
        cmd.ptr_clear = 1'b1;
        cmd.acc_init  = 1'b1;
        state_next    = ST_RESCAN;
      end
      ST_RESCAN: begin
        cmd.acc_upd = 1'b1;
        if (stat.scan_end) begin
          cmd.lvl_load = 1'b1;
          state_next   = ST_FINISH;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== bench/order_table_best_bid_ask_check.sv =====
// Checker for the order table best bid/ask block: watches both stream channels,
// keeps its own copy of the order table and compares every result transaction.
// Depends on obba_pkg for widths, the ask sentinel and the status codes.
module order_table_best_bid_ask_check #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [obba_pkg::TDATA_W-1:0]  s_tdata,
  input  logic                          s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [obba_pkg::TDATA_W-1:0]  m_tdata,
  input  logic [obba_pkg::STATUS_W-1:0] m_tuser,
  output int                            fail_count,
  output int                            pending,
  output int                            checked,
  output int                            full_seen,
  output int                            missing_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import obba_pkg::*;

  // One top-of-book report as the block should return it
  typedef struct packed {
    logic [PRICE_W-1:0] bid;
    logic [PRICE_W-1:0] ask;
    logic [COUNT_W-1:0] count;
    obba_status_t       status;
  } quote_t;

  // Shadow copy of the resting orders, oldest first
  logic [ID_W-1:0]    book_id    [DEPTH];
  logic               book_side  [DEPTH];
  logic [PRICE_W-1:0] book_price [DEPTH];
  int                 book_fill;
  logic [PRICE_W-1:0] bid_level;
  logic [PRICE_W-1:0] ask_level;

  quote_t quote_q[$];

  // Rebuild both levels from the resting orders; keep them on an empty table
  function automatic void rescan_book();
    logic [PRICE_W-1:0] bid;
    logic [PRICE_W-1:0] ask;
    if (book_fill == 0) return;
    bid = '0;
    ask = ASK_SENTINEL;
    for (int k = 0; k < book_fill; k++) begin
      if (book_side[k]) begin
        if (book_price[k] > bid) bid = book_price[k];
      end else begin
        if (book_price[k] < ask) ask = book_price[k];
      end
    end
    bid_level = bid;
    ask_level = ask;
  endfunction

  // Apply one order transaction to the shadow table and return the expected report
  function automatic quote_t apply_order(logic del, logic [ID_W-1:0] id, logic side,
                                         logic [PRICE_W-1:0] price);
    quote_t q;
    int     hit;
    q.status = STATUS_DONE;
    if (!del) begin
      if (book_fill >= DEPTH) begin
        q.status = STATUS_FULL;
      end else begin
        book_id[book_fill]    = id;
        book_side[book_fill]  = side;
        book_price[book_fill] = price;
        book_fill++;
        rescan_book();
      end
    end else begin
      hit = -1;
      for (int k = 0; k < book_fill; k++)
        if (hit < 0 && book_id[k] == id) hit = k;
      if (hit < 0) begin
        q.status = STATUS_MISSING;
      end else begin
        // close the gap, keeping arrival order
        for (int j = hit; j < book_fill - 1; j++) begin
          book_id[j]    = book_id[j+1];
          book_side[j]  = book_side[j+1];
          book_price[j] = book_price[j+1];
        end
        book_fill--;
        rescan_book();
      end
    end
    q.bid   = bid_level;
    q.ask   = ask_level;
    q.count = COUNT_W'(book_fill);
    return q;
  endfunction

  task automatic report_fault(string msg);
    if (fail_count < 10) $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // Predict on each accepted order, compare on each accepted report
  always @(posedge clk) begin : watch
    quote_t want;
    quote_t got;
    if (rst) begin
      book_fill    = 0;
      bid_level    = '0;
      ask_level    = '0;
      quote_q.delete();
      fail_count   = 0;
      checked      = 0;
      full_seen    = 0;
      missing_seen = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.bid    = m_tdata[26:0];
        got.ask    = m_tdata[53:27];
        got.count  = m_tdata[60:54];
        got.status = obba_status_t'(m_tuser);
        if (quote_q.size() == 0) begin
          report_fault($sformatf("unexpected report bid=%0d ask=%0d count=%0d status=%0d",
                                 got.bid, got.ask, got.count, got.status));
        end else begin
          want = quote_q.pop_front();
          if (got !== want)
            report_fault($sformatf({"report mismatch: expected bid=%0d ask=%0d count=%0d ",
                                    "status=%0d, got bid=%0d ask=%0d count=%0d status=%0d"},
                                   want.bid, want.ask, want.count, want.status,
                                   got.bid, got.ask, got.count, got.status));
          if (want.status == STATUS_FULL) full_seen++;
          if (want.status == STATUS_MISSING) missing_seen++;
          checked++;
        end
      end
      if (s_tvalid && s_tready)
        quote_q.insert(quote_q.size(),
                       apply_order(s_tuser, s_tdata[31:0], s_tdata[32], s_tdata[59:33]));
    end
    pending = quote_q.size();
  end

endmodule

// ===== bench/order_table_best_bid_ask_test.sv =====
// Top of the order table best bid/ask testbench: clock, reset, order stimulus,
// result back-pressure and the final verdict.
// Depends on obba_pkg, the block under test and order_table_best_bid_ask_check.
module order_table_best_bid_ask_test;
  timeunit 1ns;
  timeprecision 1ps;
  import obba_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int RANDOM_ITEMS = 1200;
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_DEL = 1'b1;
  localparam logic SIDE_SELL = 1'b0;
  localparam logic SIDE_BUY = 1'b1;

  typedef enum int {FLOW_MIX, FLOW_FILL, FLOW_DRAIN} flow_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [TDATA_W-1:0]  s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;
  logic [STATUS_W-1:0] m_tuser;

  int fail_count;
  int pending;
  int checked;
  int full_seen;
  int missing_seen;

  // Ids believed to rest in the table, oldest first; drives well-formed deletes
  logic [ID_W-1:0] rest_ids[$];
  int n_add = 0;
  int n_del = 0;
  int peak_depth = 0;
  bit quiet_send = 1'b0;

  order_table_best_bid_ask #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  order_table_best_bid_ask_check #(.DEPTH(TABLE_DEPTH)) u_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .full_seen    (full_seen),
    .missing_seen (missing_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #15ms;
    $display("order_table_best_bid_ask_test: FAIL");
    $finish;
  end

  // Mostly short gaps, a few long ones, none while quiet_send is set
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_send || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Small ids make duplicates likely; extremes and wide randoms cover the bits
  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return ID_W'($urandom_range(0, 15));
    if (r < 43) return '0;
    if (r < 46) return '1;
    return ID_W'($urandom);
  endfunction

  function automatic logic [PRICE_W-1:0] pick_price();
    int r;
    r = $urandom_range(0, 99);
    case (r % 10)
      0: begin
        if (r < 30) return '0;
        if (r < 60) return ASK_SENTINEL;
        return PRICE_W'(67108864);
      end
      1, 2, 3: return PRICE_W'($urandom_range(4999000, 5001000));
      default: return PRICE_W'($urandom_range(0, 100000000));
    endcase
  endfunction

  // Offer one order, hold it until taken, then track the resting ids
  task automatic send_order(logic del, logic [ID_W-1:0] id, logic side,
                            logic [PRICE_W-1:0] price);
    int hit;
    s_tuser  = del;
    s_tdata  = {4'b0, price, side, id};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (del == OP_ADD) begin
      if (rest_ids.size() < TABLE_DEPTH) rest_ids.insert(rest_ids.size(), id);
      n_add++;
    end else begin
      hit = -1;
      foreach (rest_ids[k])
        if (hit < 0 && rest_ids[k] == id) hit = k;
      if (hit >= 0) rest_ids.delete(hit);
      n_del++;
    end
    if (rest_ids.size() > peak_depth) peak_depth = rest_ids.size();
    @(negedge clk);
  endtask

  task automatic pause(int cycles);
    if (cycles > 0) begin
      s_tvalid = 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  task automatic send_paced(logic del, logic [ID_W-1:0] id, logic side,
                            logic [PRICE_W-1:0] price);
    send_order(del, id, side, price);
    pause(pick_gap());
  endtask

  // Result side: random short and long stalls, ready-only stretches, and two
  // long hold-offs that back the block up into its input
  initial begin : sink
    int hold;
    int cyc;
    int r;
    hold = 0;
    cyc  = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == 6000 || cyc == 90000) begin
        hold = 400;
      end else if (hold == 0 && (cyc / 1500) % 4 != 0) begin
        r = $urandom_range(0, 99);
        if (r < 20) hold = $urandom_range(1, 4);
        else if (r < 22) hold = $urandom_range(20, 60);
      end
      if (hold > 0) begin
        m_tready = 1'b0;
        hold--;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  initial begin : stimulus
    flow_t flow;
    int    blk;
    int    n_rand;
    int    add_bias;
    int    r;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: empty-table delete, price and id extremes, duplicate ids,
    // sentinel-priced sell, drain to empty with levels kept
    send_paced(OP_DEL, '0, SIDE_SELL, '0);
    send_paced(OP_ADD, '1, SIDE_SELL, ASK_SENTINEL);
    send_paced(OP_ADD, '0, SIDE_BUY, '0);
    send_paced(OP_ADD, 32'd5, SIDE_BUY, ASK_SENTINEL);
    send_paced(OP_ADD, 32'd5, SIDE_SELL, '0);
    send_paced(OP_ADD, 32'd5, SIDE_SELL, PRICE_W'(67108864));
    send_paced(OP_ADD, 32'h8000_0000, SIDE_BUY, PRICE_W'(99999999));
    send_paced(OP_DEL, 32'd5, SIDE_BUY, '1);
    send_paced(OP_DEL, 32'd1234, SIDE_SELL, '0);
    send_paced(OP_DEL, '1, SIDE_SELL, '0);
    send_paced(OP_DEL, 32'd5, SIDE_SELL, '0);
    send_paced(OP_DEL, 32'd5, SIDE_SELL, '0);
    send_paced(OP_DEL, 32'h8000_0000, SIDE_SELL, '0);
    send_paced(OP_DEL, '0, SIDE_SELL, '0);
    send_paced(OP_DEL, 32'd5, SIDE_BUY, '0);
    send_paced(OP_ADD, 32'd7, SIDE_SELL, PRICE_W'(1));
    send_paced(OP_DEL, 32'd7, SIDE_SELL, '0);

    // Random: blocks that fill, drain or churn the table, with some noise
    n_rand = 0;
    blk    = 0;
    while (n_rand < RANDOM_ITEMS) begin
      flow = (blk == 0) ? FLOW_FILL : flow_t'($urandom_range(0, 2));
      quiet_send = (blk % 3 == 2);
      add_bias = (flow == FLOW_FILL) ? 85 : (flow == FLOW_DRAIN) ? 15 : 50;
      for (int i = 0; i < 80 && n_rand < RANDOM_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < add_bias)
          send_paced(OP_ADD, pick_id(), 1'($urandom), pick_price());
        else if ($urandom_range(0, 99) < 90 && rest_ids.size() > 0)
          send_paced(OP_DEL, rest_ids[$urandom_range(0, rest_ids.size() - 1)],
                     1'($urandom), PRICE_W'($urandom));
        else
          send_paced(OP_DEL, pick_id(), 1'($urandom), PRICE_W'($urandom));
        n_rand++;
      end
      blk++;
    end
    s_tvalid = 1'b0;

    // Drain outstanding reports, then give stray output time to show up
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Sent %0d adds and %0d deletes, peak table depth %0d; %0d reports compared.",
             n_add, n_del, peak_depth, checked);
    $display("Full-table rejects: %0d, unmatched deletes: %0d, mismatches: %0d.",
             full_seen, missing_seen, fail_count);
    if (fail_count == 0) begin
      $display("order_table_best_bid_ask_test: PASS");
    end else begin
      $display("order_table_best_bid_ask_test: FAIL");
    end
    $finish;
  end

endmodule
